// ===== sv/rebinned_pdf_convolution_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rebinned histogram convolution core
// Shared property forms, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REBINNED_PDF_CONVOLUTION_CORE_ASSERT_SVH
`define REBINNED_PDF_CONVOLUTION_CORE_ASSERT_SVH

// generic clocked property with reset disable
`define RPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled beat keeps its valid and payload
`define RPC_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  `RPC_ASSERT(lbl, vld && !rdy |=> vld && $stable(sig), msg)

`endif

// ===== sv/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg
// Field widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int FACTOR_W    = 7;
  localparam int SAMPLE_W    = 16;
  localparam int MASS_W      = 32;
  localparam int INDEX_W     = 6;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [KIND_W-1:0] KIND_LEFT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GO    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_FACTOR  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_FACTOR = 2'd1;

  typedef enum logic [1:0] {
    PUSH_EMPTY,
    PUSH_PASS,
    PUSH_CONV
  } push_kind_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic rebin_start;
  } st_cmd_t;

  typedef struct packed {
    logic       load_l;
    logic       load_r;
    logic       clear;
    logic       rebin_start;
    logic       idx_clear;
    logic       term_issue;
    logic       next_out;
    logic       pass_next;
    logic       rd_conv;
    logic       push;
    push_kind_t push_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic left_empty;
    logic right_empty;
    logic rebin_busy;
    logic i_at_hi;
    logic m_last;
    logic pass_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/rpc_store.sv =====
// ----------------------------------------------------------------------------
// rpc_store
// Sample memory of one operand with fill count and in-place rebin pass.
// ----------------------------------------------------------------------------
module rpc_store import rpc_pkg::*; #(
  parameter int MAX_BINS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  st_cmd_t                      cmd,
  input  logic [SAMPLE_W-1:0]          wdata,
  input  logic [FACTOR_W-1:0]          factor,
  input  logic [$clog2(MAX_BINS)-1:0]  rd_addr,
  output logic [SAMPLE_W-1:0]          rd_data,
  output logic [$clog2(MAX_BINS+1)-1:0] count,
  output logic [$clog2(MAX_BINS+1)-1:0] nbins,
  output logic                         busy,
  output logic                         full
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);

  logic [SAMPLE_W-1:0] mem [MAX_BINS];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       nbins_r;
  logic                busy_r;
  logic                vld_r;
  logic [CW-1:0]       ptr_r;
  logic [CW-1:0]       bin_r;
  logic [FACTOR_W-1:0] grp_r;
  logic [SAMPLE_W-1:0] sum_r;

  logic [FACTOR_W-1:0] f_eff;
  logic [SAMPLE_W:0]   sum_ext;
  logic [SAMPLE_W-1:0] sum_sat;
  logic                data_last;
  logic                grp_end;
  logic                issue;
  logic                reb_wr;
  logic                load_ok;
  logic [AW-1:0]       rd_sel;

  always_comb begin
    f_eff     = (factor == '0) ? FACTOR_W'(1) : factor;
    sum_ext   = {1'b0, sum_r} + {1'b0, rd_data_r};
    sum_sat   = sum_ext[SAMPLE_W] ? '1 : sum_ext[SAMPLE_W-1:0];
    // data in flight belongs to index ptr_r-1
    data_last = (ptr_r == count_r);
    grp_end   = (grp_r == f_eff - FACTOR_W'(1)) || data_last;
    issue     = busy_r && (ptr_r != count_r);
    reb_wr    = busy_r && vld_r && grp_end;
    load_ok   = cmd.load && (count_r != CW'(MAX_BINS));
    rd_sel    = busy_r ? ptr_r[AW-1:0] : rd_addr;
  end

  // bin writes land at or below the sample just read, never on a pending read
  always_ff @(posedge clk) begin
    if (reb_wr) begin
      mem[bin_r[AW-1:0]] <= sum_sat;
    end else if (load_ok) begin
      mem[count_r[AW-1:0]] <= wdata;
    end
    rd_data_r <= mem[rd_sel];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
      end else if (load_ok) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.rebin_start) begin
        busy_r <= 1'b1;
        vld_r  <= 1'b0;
      end else if (busy_r) begin
        vld_r <= issue;
        if (vld_r && data_last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rebin_start) begin
      ptr_r <= '0;
      grp_r <= '0;
      sum_r <= '0;
      bin_r <= '0;
    end else if (busy_r) begin
      if (issue) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (vld_r) begin
        if (grp_end) begin
          sum_r <= '0;
          grp_r <= '0;
          bin_r <= bin_r + CW'(1);
        end else begin
          sum_r <= sum_sat;
          grp_r <= grp_r + FACTOR_W'(1);
        end
        if (data_last) begin
          nbins_r <= bin_r + CW'(1);
        end
      end
    end
  end

  assign rd_data = rd_data_r;
  assign count   = count_r;
  assign nbins   = nbins_r;
  assign busy    = busy_r;
  assign full    = (count_r == CW'(MAX_BINS));

endmodule

// ===== sv/rpc_datapath.sv =====
// ----------------------------------------------------------------------------
// rpc_datapath
// Factor registers, both operand stores, index counters, multiply-accumulate
// and the result register.
// ----------------------------------------------------------------------------
module rpc_datapath import rpc_pkg::*; #(
  parameter int MAX_BINS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic [SAMPLE_W-1:0]    in_sample_value,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FACTOR_W-1:0]    cfg_wdata,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [INDEX_W-1:0]     out_bin_index,
  output logic [MASS_W-1:0]      out_mass,
  output logic                   out_overflow,
  output logic                   out_last
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int MW = $clog2(2 * MAX_BINS - 1);

  logic [FACTOR_W-1:0] left_factor_r;
  logic [FACTOR_W-1:0] right_factor_r;
  logic                dropped_r;

  st_cmd_t             l_cmd, r_cmd;
  logic [SAMPLE_W-1:0] l_rd, r_rd;
  logic [CW-1:0]       l_cnt, r_cnt, l_nb, r_nb;
  logic                l_busy, r_busy, l_full, r_full;
  logic [AW-1:0]       r_addr;

  logic [MW-1:0]       m_r;
  logic [AW-1:0]       i_r;
  logic [MW:0]         lo_t;
  logic [AW-1:0]       lo;
  logic [MW-1:0]       diff;
  logic [CW-1:0]       src_cnt;
  logic [SAMPLE_W-1:0] src_rd;
  logic                pass_last;
  logic                m_last;

  logic                v1_r, v2_r;
  logic [MASS_W-1:0]   prod_r;
  logic [MASS_W-1:0]   acc_r;
  logic                sat_r;
  logic [MASS_W:0]     acc_sum;

  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [MASS_W-1:0]   out_mass_r;
  logic                out_ovf_r;
  logic                out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_factor_r  <= FACTOR_W'(1);
      right_factor_r <= FACTOR_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_FACTOR:  left_factor_r  <= cfg_wdata;
        CFG_RIGHT_FACTOR: right_factor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dropped_r <= 1'b0;
    end else if (cmd.clear) begin
      dropped_r <= 1'b0;
    end else if ((cmd.load_l && l_full) || (cmd.load_r && r_full)) begin
      dropped_r <= 1'b1;
    end
  end

  always_comb begin
    l_cmd = '{load: cmd.load_l, clear: cmd.clear, rebin_start: cmd.rebin_start};
    r_cmd = '{load: cmd.load_r, clear: cmd.clear, rebin_start: cmd.rebin_start};
    diff   = m_r - MW'(i_r);
    r_addr = cmd.rd_conv ? AW'(diff) : i_r;
  end

  rpc_store #(.MAX_BINS(MAX_BINS)) u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (l_cmd),
    .wdata   (in_sample_value),
    .factor  (left_factor_r),
    .rd_addr (i_r),
    .rd_data (l_rd),
    .count   (l_cnt),
    .nbins   (l_nb),
    .busy    (l_busy),
    .full    (l_full)
  );

  rpc_store #(.MAX_BINS(MAX_BINS)) u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (r_cmd),
    .wdata   (in_sample_value),
    .factor  (right_factor_r),
    .rd_addr (r_addr),
    .rd_data (r_rd),
    .count   (r_cnt),
    .nbins   (r_nb),
    .busy    (r_busy),
    .full    (r_full)
  );

  always_comb begin
    // first left index of the next output bin: max(0, m+1 - (nr-1))
    lo_t = {1'b0, m_r} + (MW+1)'(2);
    lo   = (lo_t > (MW+1)'(r_nb)) ? AW'(lo_t - (MW+1)'(r_nb)) : '0;
    src_cnt   = (l_cnt == '0) ? r_cnt : l_cnt;
    src_rd    = (l_cnt == '0) ? r_rd : l_rd;
    pass_last = ((CW'(i_r) + CW'(1)) == src_cnt);
    m_last    = (m_r == (MW'(l_nb) + MW'(r_nb) - MW'(2)));
    acc_sum   = {1'b0, acc_r} + {1'b0, prod_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      m_r <= '0;
      i_r <= '0;
    end else if (cmd.next_out) begin
      m_r <= m_r + MW'(1);
      i_r <= lo;
    end else if (cmd.term_issue || cmd.pass_next) begin
      i_r <= i_r + AW'(1);
    end
  end

  // read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.term_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= MASS_W'(l_rd) * MASS_W'(r_rd);
    end
    if (cmd.idx_clear || cmd.next_out) begin
      acc_r <= '0;
      sat_r <= 1'b0;
    end else if (v2_r) begin
      acc_r <= acc_sum[MASS_W-1:0];
      sat_r <= sat_r | acc_sum[MASS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_ovf_r <= dropped_r;
      case (cmd.push_kind)
        PUSH_PASS: begin
          out_idx_r  <= INDEX_W'(i_r);
          out_mass_r <= {src_rd, {SAMPLE_W{1'b0}}};
          out_last_r <= pass_last;
        end
        PUSH_CONV: begin
          out_idx_r  <= INDEX_W'(m_r);
          out_mass_r <= sat_r ? '1 : acc_r;
          out_last_r <= m_last;
        end
        default: begin
          out_idx_r  <= '0;
          out_mass_r <= '0;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts.left_empty  = (l_cnt == '0);
    sts.right_empty = (r_cnt == '0);
    sts.rebin_busy  = l_busy || r_busy;
    sts.i_at_hi     = (MW'(i_r) == m_r) || ((CW'(i_r) + CW'(1)) == l_nb);
    sts.m_last      = m_last;
    sts.pass_last   = pass_last;
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = out_idx_r;
  assign out_mass      = out_mass_r;
  assign out_overflow  = out_ovf_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/rpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpc_ctrl
// Job sequencer: sample loads, rebin wait, convolution walk, pass-through
// and result hand-off.
// ----------------------------------------------------------------------------
module rpc_ctrl import rpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REBIN,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_CONV_OUT,
    S_PASS_RD,
    S_PASS_OUT,
    S_EMPTY_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  always_comb begin
    accept    = in_valid && (state_r == S_IDLE);
    state_nxt = state_r;
    cmd       = '0;
    cmd.push_kind = PUSH_EMPTY;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_LEFT:  cmd.load_l = 1'b1;
            KIND_RIGHT: cmd.load_r = 1'b1;
            KIND_GO: begin
              cmd.idx_clear = 1'b1;
              if (sts.left_empty && sts.right_empty) begin
                state_nxt = S_EMPTY_OUT;
              end else if (sts.left_empty || sts.right_empty) begin
                state_nxt = S_PASS_RD;
              end else begin
                cmd.rebin_start = 1'b1;
                state_nxt       = S_REBIN;
              end
            end
            default: ;
          endcase
        end
      end
      S_REBIN: begin
        if (!sts.rebin_busy) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.term_issue = 1'b1;
        cmd.rd_conv    = 1'b1;
        if (sts.i_at_hi) begin
          state_nxt = S_DRAIN1;
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_CONV_OUT;
      S_CONV_OUT: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_CONV;
          if (sts.m_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.next_out = 1'b1;
            state_nxt    = S_ISSUE;
          end
        end
      end
      S_PASS_RD: state_nxt = S_PASS_OUT;
      S_PASS_OUT: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_PASS;
          if (sts.pass_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.pass_next = 1'b1;
            state_nxt     = S_PASS_RD;
          end
        end
      end
      S_EMPTY_OUT: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = PUSH_EMPTY;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== sv/rebinned_pdf_convolution_core.sv =====
// ----------------------------------------------------------------------------
// rebinned_pdf_convolution_core
// Rebinned linear convolution of two loaded probability histograms.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): kind 0 and 1 load one Q0.16 sample into
// the left or right store, one beat per cycle; a sample beyond MAX_BINS is
// dropped and flags overflow. Kind 2 starts the job; kind 3 is ignored.
// Result channel (out_valid/out_ready): one beat per output bin, last on the
// final bin. Both stores empty gives one zero beat; one store empty streams
// the other's raw samples, each sample read before its beat is placed.
// With both stores loaded a job runs a rebin pass, then for each output bin
// m issues its terms (overlap of the two rebinned operands at m) through the
// single read port of each store into one 16x16 multiplier and a 32-bit
// saturating accumulator, drains them and places the result.
// The input is held off from the go beat until the last result is placed in
// the output register; loads for the next job are then taken while that
// result waits. A stalled receiver holds the sequencer in its output state.
// Reset (synchronous, rst_n low) empties both stores, clears the overflow
// flag and sets both factors to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rebinned_pdf_convolution_core import rpc_pkg::*; #(
  parameter int MAX_BINS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [SAMPLE_W-1:0]    in_sample_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [INDEX_W-1:0]     out_bin_index,
  output logic [MASS_W-1:0]      out_mass,
  output logic                   out_overflow,
  output logic                   out_last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [FACTOR_W-1:0]    cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  rpc_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_value (in_sample_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_bin_index   (out_bin_index),
    .out_mass        (out_mass),
    .out_overflow    (out_overflow),
    .out_last        (out_last)
  );

endmodule

// ===== sv/rpc_checker.sv =====
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks of the convolution core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rebinned_pdf_convolution_core_assert.svh"

module rpc_checker import rpc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [KIND_W-1:0]  in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] out_bin_index,
  input logic [MASS_W-1:0]  out_mass,
  input logic               out_overflow,
  input logic               out_last
);

  `RPC_ASSERT_HOLD(a_out_hold, out_valid, out_ready, out_mass, "stalled result beat changed")

  // a go beat always starts a job that blocks the input
  `RPC_ASSERT(a_go_blocks, in_valid && in_ready && in_kind == KIND_GO |=> !in_ready, "input open after go")

  // a non-final result means the job is still running
  `RPC_ASSERT(a_mid_job, out_valid && !out_last |-> !in_ready, "input open in mid job")

  // result bins of one job come in order
  `RPC_ASSERT(a_bin_step, out_valid && out_ready && !out_last |=> !out_valid || out_bin_index == 6'($past(out_bin_index) + 6'd1), "result bin index skipped")

  // overflow flag cannot change inside a job
  `RPC_ASSERT(a_ovf_steady, out_valid && out_ready && !out_last |=> !out_valid || out_overflow == $past(out_overflow), "overflow flag changed in job")

endmodule

bind rebinned_pdf_convolution_core rpc_checker u_rpc_checker (.*);
